FILE: design/etm_pkg.sv
// package: sha-256 constants, state type and sizing for the mnemonic index core
`default_nettype none
package etm_pkg;
    localparam int ENTROPY_BYTES_DEF = 16;
    localparam int IDX_BITS = 11;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction
endpackage
`default_nettype wire

FILE: design/entropy_to_mnemonic_indices_core.sv
// top level: entropy bytes in, bip-39 mnemonic word indices out
`default_nettype none
// Accepts entropy bytes one request at a time, first byte first. Each accepted
// byte is shifted into the entropy register. The byte that finishes a group of
// ENTROPY_BYTES starts the digest: ST_LOAD loads the padded message schedule
// and the initial hash, ST_ROUND runs the SHA-256 rounds through one shared
// round unit (the message expansion rides along in the same cycle as each
// round), ST_FINAL adds the initial hash to the first digest word, and then
// (8*ENTROPY_BYTES + ENTROPY_BYTES/4)/11 indices leave one per cycle from a
// shift register holding entropy and checksum, most significant bit first,
// with o_last_word on the final one. i_stall holds an index in place. While a
// group is hashed or emitted o_stall is high, so no new byte is taken before
// the last index leaves. Only the top ENTROPY_BYTES/4 digest bits are kept.
module entropy_to_mnemonic_indices_core #(
    parameter int ENTROPY_BYTES = etm_pkg::ENTROPY_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_entropy_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [10:0]      o_word_index,
    output logic             o_last_word
);
    localparam int EBITS   = ENTROPY_BYTES * 8;
    localparam int CS_BITS = ENTROPY_BYTES / 4;
    localparam int TBITS   = EBITS + CS_BITS;
    localparam int NWORDS  = TBITS / etm_pkg::IDX_BITS;
    localparam int BCW     = $clog2(ENTROPY_BYTES + 1);
    localparam int WCW     = $clog2(NWORDS + 1);
    localparam int SRW     = TBITS + etm_pkg::IDX_BITS;
    localparam logic [63:0] LEN_BITS = 64'(EBITS);

    etm_pkg::t_state r_state, n_state;
    logic [BCW-1:0]  r_byte_count;
    logic [6:0]      r_round_count;
    logic [WCW-1:0]  r_word_count;
    // entropy held as a shift line, first byte at the top
    logic [EBITS-1:0] r_ent;
    logic [31:0]      r_w [16];
    logic [31:0]      r_v [8];
    logic [SRW-1:0]   r_sr;

    logic accept_in, emit_done;
    logic [511:0] pad_block;
    logic [31:0]  w_new, w_cur, t1, t2, s0, s1, es0, es1, ch, mj;

    assign accept_in = i_valid && !o_stall;
    assign emit_done = o_valid && !i_stall && (r_word_count == WCW'(NWORDS - 1));

    // padded single block: entropy, 0x80 marker, zeros, bit length
    always_comb begin
        pad_block = '0;
        pad_block[511 -: EBITS] = r_ent;
        pad_block[511 - EBITS -: 8] = 8'h80;
        pad_block[63:0] = LEN_BITS;
    end

    // shared round unit with message expansion
    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]}
             ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
             ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = (r_round_count < 7'd16) ? r_w[0] : w_new;
        es1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
              ^ {r_v[4][24:0], r_v[4][31:25]};
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + es1 + ch + etm_pkg::round_k(r_round_count[5:0]) + w_cur;
        es0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
              ^ {r_v[0][21:0], r_v[0][31:22]};
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2  = es0 + mj;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            etm_pkg::ST_FILL:
                if (accept_in && r_byte_count == BCW'(ENTROPY_BYTES - 1))
                    n_state = etm_pkg::ST_LOAD;
            etm_pkg::ST_LOAD:  n_state = etm_pkg::ST_ROUND;
            etm_pkg::ST_ROUND: if (r_round_count == 7'd63) n_state = etm_pkg::ST_FINAL;
            etm_pkg::ST_FINAL: n_state = etm_pkg::ST_EMIT;
            etm_pkg::ST_EMIT:  if (emit_done) n_state = etm_pkg::ST_FILL;
            default:           n_state = etm_pkg::ST_FILL;
        endcase
    end

    // outputs
    always_comb begin
        o_stall      = (r_state != etm_pkg::ST_FILL);
        o_valid      = (r_state == etm_pkg::ST_EMIT);
        o_word_index = r_sr[SRW-1 -: 11];
        o_last_word  = (r_word_count == WCW'(NWORDS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= etm_pkg::ST_FILL;
            r_byte_count  <= '0;
            r_round_count <= '0;
            r_word_count  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                etm_pkg::ST_FILL: if (accept_in) r_byte_count <= r_byte_count + 1'b1;
                etm_pkg::ST_ROUND: r_round_count <= r_round_count + 1'b1;
                etm_pkg::ST_FINAL: begin
                    r_round_count <= '0;
                    r_byte_count  <= '0;
                end
                etm_pkg::ST_EMIT:
                    if (o_valid && !i_stall)
                        r_word_count <= emit_done ? '0 : r_word_count + 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            etm_pkg::ST_FILL:
                if (accept_in) r_ent <= {r_ent[EBITS-9:0], i_entropy_byte};
            etm_pkg::ST_LOAD: begin
                for (int i = 0; i < 16; i++) r_w[i] <= pad_block[511 - 32*i -: 32];
                for (int i = 0; i < 8; i++) r_v[i] <= etm_pkg::init_h(3'(i));
            end
            etm_pkg::ST_ROUND: begin
                // rolling schedule window: slot 0 holds w[t] for t < 16, w[t-16] later
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_cur;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            etm_pkg::ST_FINAL: begin
                logic [31:0] h0;
                h0 = r_v[0] + etm_pkg::init_h(3'd0);
                r_sr <= {r_ent, h0[31 -: CS_BITS], {etm_pkg::IDX_BITS{1'b0}}};
            end
            etm_pkg::ST_EMIT:
                if (o_valid && !i_stall) r_sr <= r_sr << etm_pkg::IDX_BITS;
            default: ;
        endcase
    end
endmodule
`default_nettype wire
